[rtl/assert_macros.svh]
// Assertion macros used by the checker file of the block pool allocator.
// Standalone header; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock, switched off in reset.
`define FBPA_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Concurrent assertion that also holds while reset is asserted.
`define FBPA_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

[rtl/fbpa_pkg.sv]
// Shared types and constants of the fixed block pool allocator.
// No dependencies; used by every RTL module of the block.
package fbpa_pkg;

   localparam int MAX_BLOCKS_DEFAULT = 1024;

   localparam int ADDR_W      = 32;
   localparam int CFG_SIZE_W  = 16;
   localparam int CFG_COUNT_W = 11;
   localparam int STATUS_W    = 3;
   localparam int PADDR_W     = 4;
   localparam int PDATA_W     = 32;

   // register reset values
   localparam logic [ADDR_W-1:0]      BASE_RESET  = 32'd0;
   localparam logic [CFG_SIZE_W-1:0]  SIZE_RESET  = 16'd64;
   localparam logic [CFG_COUNT_W-1:0] COUNT_RESET = 11'd1024;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_BASE_ADDRESS = 2'd0;
   localparam logic [1:0] REG_BLOCK_SIZE   = 2'd1;
   localparam logic [1:0] REG_BLOCK_COUNT  = 2'd2;

   // operations
   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK      = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_NULL    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_FULL    = 3'd4;

   typedef struct packed {
      logic              operation;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]      block_address;
      logic [STATUS_W-1:0]    status;
      logic [CFG_COUNT_W-1:0] free_left;
   } rsp_type;

   // register file to datapath
   typedef struct packed {
      logic [ADDR_W-1:0]      base_address;
      logic [CFG_SIZE_W-1:0]  block_size;
      logic [CFG_COUNT_W-1:0] block_count;
      logic                   refill;
      logic [CFG_COUNT_W-1:0] refill_count;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic                load_item;
      logic                pop;
      logic                mul;
      logic                set_addr;
      logic                prep;
      logic                div_init;
      logic                div_step;
      logic                push;
      logic                set_status;
      logic [STATUS_W-1:0] status;
      logic                load_out;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic op_free;
      logic addr_null;
      logic count_zero;
      logic range_ok;
      logic div_last;
      logic rem_zero;
      logic list_full;
   } flags_type;

endpackage

[rtl/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator.
// Depends on fbpa_pkg, fbpa_regs, fbpa_ctrl and fbpa_datapath.
//
// Pool of equal blocks kept as a LIFO stack of free block indexes.
// Request channel (req_valid/req_stall/req_data): one transaction per
// operation, allocate or free an address. Response channel
// (rsp_valid/rsp_stall/rsp_data): exactly one transaction per request with
// the block address, a status code and the free count after the operation.
// Configuration goes through the APB-style port; pready is tied high.
// Items are handled one at a time; a new request is taken only once the
// last response is loaded. An allocate pops the stack, reads the index,
// multiplies it by the block size and adds the base. A free is range-checked
// and then goes through the bit-serial divider that checks block alignment;
// null or out-of-range frees finish without the divider.
// Reset loads the register defaults and a full free list, with no clearing
// pass: a low-water mark tells which stack entries still hold their refill
// value. Writing block_count refills the list the same way.
// The response sits in an output register; a stalled receiver holds it, and
// the block still accepts and works on the next request, waiting at the end
// until the register is free.
module fixed_block_pool_allocator #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  fbpa_pkg::req_type             req_data,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output fbpa_pkg::rsp_type             rsp_data,
   // configuration
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fbpa_pkg::PADDR_W-1:0]  paddr,
   input  logic [fbpa_pkg::PDATA_W-1:0]  pwdata,
   output logic [fbpa_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready
);

   fbpa_pkg::cfg_type   cfg;
   fbpa_pkg::cmd_type   cmd;
   fbpa_pkg::flags_type flags;

   fbpa_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // sequencing: one request in flight, response register decoupled
   fbpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .flags     (flags),
      .cmd       (cmd)
   );

   // stack, address math, divider and response register
   fbpa_datapath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cfg      (cfg),
      .cmd      (cmd),
      .flags    (flags),
      .rsp_data (rsp_data)
   );

endmodule

[rtl/fbpa_regs.sv]
// APB-style configuration registers of the block pool allocator.
// Depends on fbpa_pkg.
module fbpa_regs (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [fbpa_pkg::PADDR_W-1:0]  paddr,
   input  logic [fbpa_pkg::PDATA_W-1:0]  pwdata,
   output logic [fbpa_pkg::PDATA_W-1:0]  prdata,
   output logic                          pready,
   output fbpa_pkg::cfg_type             cfg
);

   logic [fbpa_pkg::ADDR_W-1:0]      base_ff;
   logic [fbpa_pkg::CFG_SIZE_W-1:0]  size_ff;
   logic [fbpa_pkg::CFG_COUNT_W-1:0] count_ff;
   logic                             wr_en;
   logic [1:0]                       reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff  <= fbpa_pkg::BASE_RESET;
         size_ff  <= fbpa_pkg::SIZE_RESET;
         count_ff <= fbpa_pkg::COUNT_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            fbpa_pkg::REG_BASE_ADDRESS: base_ff  <= pwdata;
            fbpa_pkg::REG_BLOCK_SIZE:   size_ff  <= pwdata[fbpa_pkg::CFG_SIZE_W-1:0];
            fbpa_pkg::REG_BLOCK_COUNT:  count_ff <= pwdata[fbpa_pkg::CFG_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         fbpa_pkg::REG_BASE_ADDRESS: prdata = base_ff;
         fbpa_pkg::REG_BLOCK_SIZE:   prdata = 32'(size_ff);
         fbpa_pkg::REG_BLOCK_COUNT:  prdata = 32'(count_ff);
         default:                    prdata = '0;
      endcase
   end

   // a block-count write refills the free list in the same edge
   assign cfg.base_address = base_ff;
   assign cfg.block_size   = size_ff;
   assign cfg.block_count  = count_ff;
   assign cfg.refill       = wr_en && (reg_idx == fbpa_pkg::REG_BLOCK_COUNT);
   assign cfg.refill_count = pwdata[fbpa_pkg::CFG_COUNT_W-1:0];

endmodule

[rtl/fbpa_ctrl.sv]
// Sequencing state machine of the block pool allocator.
// Depends on fbpa_pkg; drives fbpa_datapath through cmd_type.
module fbpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  fbpa_pkg::flags_type   flags,
   output fbpa_pkg::cmd_type     cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_A_READ,
      S_A_ADD,
      S_F_RANGE,
      S_F_DIV,
      S_F_TEST,
      S_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (!flags.op_free) begin
               if (flags.count_zero) begin
                  cmd.set_status = 1'b1;
                  cmd.status     = fbpa_pkg::STATUS_EMPTY;
                  state_in       = S_FINISH;
               end else begin
                  cmd.pop  = 1'b1;
                  state_in = S_A_READ;
               end
            end else if (flags.addr_null) begin
               cmd.set_status = 1'b1;
               cmd.status     = fbpa_pkg::STATUS_NULL;
               state_in       = S_FINISH;
            end else begin
               cmd.prep = 1'b1;
               state_in = S_F_RANGE;
            end
         end
         S_A_READ: begin
            cmd.mul  = 1'b1;
            state_in = S_A_ADD;
         end
         S_A_ADD: begin
            cmd.set_addr   = 1'b1;
            cmd.set_status = 1'b1;
            cmd.status     = fbpa_pkg::STATUS_OK;
            state_in       = S_FINISH;
         end
         S_F_RANGE: begin
            if (!flags.range_ok) begin
               cmd.set_status = 1'b1;
               cmd.status     = fbpa_pkg::STATUS_INVALID;
               state_in       = S_FINISH;
            end else begin
               cmd.div_init = 1'b1;
               state_in     = S_F_DIV;
            end
         end
         S_F_DIV: begin
            cmd.div_step = 1'b1;
            if (flags.div_last) begin
               state_in = S_F_TEST;
            end
         end
         S_F_TEST: begin
            cmd.set_status = 1'b1;
            if (!flags.rem_zero) begin
               cmd.status = fbpa_pkg::STATUS_INVALID;
            end else if (flags.list_full) begin
               cmd.status = fbpa_pkg::STATUS_FULL;
            end else begin
               cmd.push   = 1'b1;
               cmd.status = fbpa_pkg::STATUS_OK;
            end
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/fbpa_datapath.sv]
// Free-list stack, address arithmetic and bit-serial divider of the pool allocator.
// Depends on fbpa_pkg; commanded by fbpa_ctrl.
module fbpa_datapath #(
   parameter int MAX_BLOCKS = fbpa_pkg::MAX_BLOCKS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  fbpa_pkg::req_type     req_data,
   input  fbpa_pkg::cfg_type     cfg,
   input  fbpa_pkg::cmd_type     cmd,
   output fbpa_pkg::flags_type   flags,
   output fbpa_pkg::rsp_type     rsp_data
);

   localparam int IW     = $clog2(MAX_BLOCKS);
   localparam int CW     = $clog2(MAX_BLOCKS + 1);
   localparam int CMP_W  = (CW > fbpa_pkg::CFG_COUNT_W) ? CW : fbpa_pkg::CFG_COUNT_W;
   localparam int SPAN_W = fbpa_pkg::CFG_SIZE_W + CW;
   localparam int OCMP_W = (SPAN_W > fbpa_pkg::ADDR_W) ? SPAN_W : fbpa_pkg::ADDR_W;
   localparam int DCW    = (IW > 1) ? $clog2(IW) : 1;
   localparam logic [CMP_W-1:0] MAX_EXT = CMP_W'(MAX_BLOCKS);
   localparam logic [CW-1:0] RESET_N =
      CW'((int'(fbpa_pkg::COUNT_RESET) > MAX_BLOCKS) ? MAX_BLOCKS
                                                      : int'(fbpa_pkg::COUNT_RESET));

   // effective pool size: block count capped at the stack depth
   function automatic logic [CW-1:0] cap_count(input logic [fbpa_pkg::CFG_COUNT_W-1:0] c);
      logic [CMP_W-1:0] c_ext;
      c_ext = CMP_W'(c);
      if (c_ext > MAX_EXT) begin
         c_ext = MAX_EXT;
      end
      return c_ext[CW-1:0];
   endfunction

   logic [IW-1:0]             stack_mem [MAX_BLOCKS];

   fbpa_pkg::req_type         item_ff;
   logic [CW-1:0]             count_ff;
   logic [CW-1:0]             low_ff;
   logic [IW-1:0]             pos_ff;
   logic                      fresh_ff;
   logic [IW-1:0]             rdata_ff;
   logic [31:0]               prod_ff;
   logic [31:0]               res_addr_ff;
   logic [2:0]                res_status_ff;
   logic [31:0]               offset_ff;
   logic [SPAN_W-1:0]         span_ff;
   logic [31:0]               rem_ff;
   logic [31:0]               dsh_ff;
   logic [IW-1:0]             quo_ff;
   logic [DCW-1:0]            dcnt_ff;
   fbpa_pkg::rsp_type         out_ff;

   logic [CW-1:0]             pool_n;
   logic [CW-1:0]             refill_n;
   logic [CW-1:0]             pop_cnt;
   logic [IW-1:0]             blk_idx;
   logic                      rem_ge;
   logic [CMP_W-1:0]          left_ext;

   assign pool_n   = cap_count(cfg.block_count);
   assign refill_n = cap_count(cfg.refill_count);
   assign pop_cnt  = count_ff - CW'(1);
   assign rem_ge   = (rem_ff >= dsh_ff);
   assign left_ext = CMP_W'(count_ff);

   // entries below the low-water mark were never rewritten since the refill
   assign blk_idx = fresh_ff ? pos_ff : rdata_ff;

   // free count and low-water mark
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= RESET_N;
         low_ff   <= RESET_N;
      end else if (cfg.refill) begin
         count_ff <= refill_n;
         low_ff   <= refill_n;
      end else if (cmd.pop) begin
         count_ff <= pop_cnt;
         if (pop_cnt < low_ff) begin
            low_ff <= pop_cnt;
         end
      end else if (cmd.push) begin
         count_ff <= count_ff + CW'(1);
      end
   end

   // stack memory, registered read
   always_ff @(posedge clock) begin
      if (cmd.push) begin
         stack_mem[count_ff[IW-1:0]] <= quo_ff;
      end
      if (cmd.pop) begin
         rdata_ff <= stack_mem[pop_cnt[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff     <= req_data;
         res_addr_ff <= '0;
      end
      if (cmd.pop) begin
         pos_ff   <= pop_cnt[IW-1:0];
         fresh_ff <= (pop_cnt < low_ff);
      end
      if (cmd.mul) begin
         prod_ff <= 32'(blk_idx) * 32'(cfg.block_size);
      end
      if (cmd.set_addr) begin
         res_addr_ff <= cfg.base_address + prod_ff;
      end
      if (cmd.set_status) begin
         res_status_ff <= cmd.status;
      end
      if (cmd.prep) begin
         offset_ff <= item_ff.address - cfg.base_address;
         span_ff   <= SPAN_W'(cfg.block_size) * SPAN_W'(pool_n);
      end
      // restoring division, one quotient bit per cycle
      if (cmd.div_init) begin
         rem_ff  <= offset_ff;
         dsh_ff  <= 32'(cfg.block_size) << (IW - 1);
         quo_ff  <= '0;
         dcnt_ff <= DCW'(IW - 1);
      end else if (cmd.div_step) begin
         if (rem_ge) begin
            rem_ff <= rem_ff - dsh_ff;
         end
         dsh_ff  <= dsh_ff >> 1;
         quo_ff  <= IW'({quo_ff, rem_ge});
         dcnt_ff <= dcnt_ff - DCW'(1);
      end
      if (cmd.load_out) begin
         out_ff.block_address <= res_addr_ff;
         out_ff.status        <= res_status_ff;
         out_ff.free_left     <= left_ext[fbpa_pkg::CFG_COUNT_W-1:0];
      end
   end

   assign flags.op_free    = (item_ff.operation == fbpa_pkg::OP_FREE);
   assign flags.addr_null  = (item_ff.address == '0);
   assign flags.count_zero = (count_ff == '0);
   assign flags.range_ok   = (OCMP_W'(offset_ff) < OCMP_W'(span_ff));
   assign flags.div_last   = (dcnt_ff == '0);
   assign flags.rem_zero   = (rem_ff == '0);
   assign flags.list_full  = (count_ff >= pool_n);

   assign rsp_data = out_ff;

endmodule

[rtl/fbpa_checker.sv]
// Port-level checks of the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fbpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input fbpa_pkg::rsp_type rsp_data
);

   logic rsp_held;
   logic rsp_failed;
   logic rsp_empty;
   logic req_take;

   assign rsp_held   = rsp_valid && rsp_stall;
   assign rsp_failed = rsp_valid && (rsp_data.status != fbpa_pkg::STATUS_OK);
   assign rsp_empty  = rsp_valid && (rsp_data.status == fbpa_pkg::STATUS_EMPTY);
   assign req_take   = req_valid && !req_stall;

   `FBPA_ASSERT(a_rsp_hold, clock, reset, (rsp_held |=> rsp_valid && $stable(rsp_data)))
   `FBPA_ASSERT(a_fail_no_addr, clock, reset, (rsp_failed |-> rsp_data.block_address == '0))
   `FBPA_ASSERT(a_empty_zero, clock, reset, (rsp_empty |-> rsp_data.free_left == '0))
   `FBPA_ASSERT(a_busy_after_accept, clock, reset, (req_take |=> req_stall))
   `FBPA_ASSERT_NORST(a_reset_clears, clock, (reset |=> !rsp_valid))

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

[dv/fixed_block_pool_allocator_tb.sv]
// Self-checking testbench for fixed_block_pool_allocator: directed and random
// allocate/free traffic, register changes and a predictor of the free-list stack.
// Depends on fbpa_pkg and the fixed_block_pool_allocator RTL.
module fixed_block_pool_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ADDR_W      = fbpa_pkg::ADDR_W;
   localparam int CFG_SIZE_W  = fbpa_pkg::CFG_SIZE_W;
   localparam int CFG_COUNT_W = fbpa_pkg::CFG_COUNT_W;
   localparam int PADDR_W     = fbpa_pkg::PADDR_W;
   localparam int PDATA_W     = fbpa_pkg::PDATA_W;

   localparam int POOL_MAX       = fbpa_pkg::MAX_BLOCKS_DEFAULT;
   localparam int PHASE_ITEMS    = 130;   // random transactions per register setting
   localparam int RANDOM_PHASES  = 10;
   localparam int LONG_HOLD      = 400;   // receiver hold-off, long enough to back up the block
   localparam int DRAIN_CYCLES   = 20;    // settle time, longer than the slowest free
   localparam int WATCHDOG_LIMIT = 4000;  // cycles without any accepted transaction

   // ------------------------------------------------------------------
   // DUT signals; every input has a known value from time zero
   // ------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   fbpa_pkg::req_type    req_data = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   fbpa_pkg::rsp_type    rsp_data;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic [PADDR_W-1:0]   paddr = '0;
   logic [PDATA_W-1:0]   pwdata = '0;
   logic [PDATA_W-1:0]   prdata;
   logic                 pready;

   fixed_block_pool_allocator uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow of the pool: register values, free-list stack and its depth
   // ------------------------------------------------------------------
   logic [ADDR_W-1:0]      cfg_base;
   logic [CFG_SIZE_W-1:0]  cfg_size;
   logic [CFG_COUNT_W-1:0] cfg_count;
   logic [9:0]             free_stack [POOL_MAX];
   logic [CFG_COUNT_W-1:0] free_count;

   fbpa_pkg::req_type pending_reqs [$];   // built by the sequencer, drained by the driver
   fbpa_pkg::rsp_type pending_rsps [$];   // predicted responses, oldest first

   int n_queued      = 0;
   int n_rsps        = 0;
   int n_settings    = 0;
   int errors        = 0;
   int status_seen [5];
   int hold_request  = 0;       // bumped by the sequencer to ask for a long hold-off

   // blocks actually in the pool: count register capped at the stack depth
   function automatic int unsigned pool_blocks();
      return (cfg_count > POOL_MAX) ? POOL_MAX : cfg_count;
   endfunction

   // reset and every block_count write: all indexes free, highest on top
   function automatic void refill_pool();
      int unsigned n;
      n = pool_blocks();
      for (int i = 0; i < POOL_MAX; i++)
         free_stack[i] = (i < n) ? 10'(i) : '0;
      free_count = CFG_COUNT_W'(n);
   endfunction

   // apply one accepted request to the shadow pool and return its response
   function automatic fbpa_pkg::rsp_type predict_pool_response(fbpa_pkg::req_type r);
      fbpa_pkg::rsp_type p;
      int unsigned       n;
      logic [31:0]       offset;
      longint unsigned   span;
      n = pool_blocks();
      p = '0;
      if (r.operation == fbpa_pkg::OP_ALLOC) begin
         if (free_count == 0 || free_count > POOL_MAX) begin
            p.status = fbpa_pkg::STATUS_EMPTY;
         end else begin
            free_count      = free_count - 1'b1;
            // wraps modulo 2^32
            p.block_address = cfg_base + 32'(free_stack[free_count]) * 32'(cfg_size);
            p.status        = fbpa_pkg::STATUS_OK;
         end
      end else if (r.address == '0) begin
         // null is ignored even when block 0 sits at address 0
         p.status = fbpa_pkg::STATUS_NULL;
      end else begin
         offset = r.address - cfg_base;
         span   = longint'(cfg_size) * longint'(n);
         if (cfg_size == 0 || offset >= span || (offset % cfg_size) != 0) begin
            p.status = fbpa_pkg::STATUS_INVALID;
         end else if (free_count >= n) begin
            p.status = fbpa_pkg::STATUS_FULL;
         end else begin
            // no ownership tracking: a double free that fits is pushed
            free_stack[free_count] = 10'(offset / cfg_size);
            free_count             = free_count + 1'b1;
            p.status               = fbpa_pkg::STATUS_OK;
         end
      end
      p.free_left = free_count;
      status_seen[p.status]++;
      return p;
   endfunction

   // ------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps
   // ------------------------------------------------------------------
   logic tx_offering;
   int   tx_burst_left = 0;
   int   tx_gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         // prediction happens at acceptance; order of acceptance is order of results
         if (req_valid && !req_stall) begin
            pending_rsps.push_back(predict_pool_response(req_data));
            tx_offering = 1'b0;
         end else begin
            tx_offering = req_valid;   // a stalled transaction stays put
         end
         if (!tx_offering) begin
            if (tx_gap_left > 0) begin
               tx_gap_left--;
            end else if (pending_reqs.size() != 0) begin
               req_data <= pending_reqs.pop_front();
               tx_offering = 1'b1;
               if (tx_burst_left > 0)
                  tx_burst_left--;
               if (tx_burst_left == 0) begin
                  tx_burst_left = $urandom_range(1, 24);
                  tx_gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 14);
               end
            end
         end
         req_valid <= tx_offering;
      end
   end

   // ------------------------------------------------------------------
   // Response monitor and receiver stall pattern
   // ------------------------------------------------------------------
   int                rx_cycle   = 0;
   int                rx_mode    = 0;
   int                hold_left  = 0;
   int                hold_seen  = 0;
   logic              rx_stall_next;
   fbpa_pkg::rsp_type want;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_rsps++;
            if (pending_rsps.size() == 0) begin
               $error("unexpected response transaction: %p", rsp_data);
               errors++;
            end else begin
               want = pending_rsps.pop_front();
               if (rsp_data.block_address !== want.block_address) begin
                  $error("block_address: expected %h, got %h",
                         want.block_address, rsp_data.block_address);
                  errors++;
               end
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  errors++;
               end
               if (rsp_data.free_left !== want.free_left) begin
                  $error("free_left: expected %0d, got %0d", want.free_left, rsp_data.free_left);
                  errors++;
               end
            end
         end

         // stall pattern: random mode switches, long hold-off on request
         rx_cycle++;
         if (hold_seen != hold_request) begin
            hold_seen = hold_request;
            hold_left = LONG_HOLD;
         end
         if (rx_cycle % 97 == 0)
            rx_mode = $urandom_range(0, 3);
         if (hold_left > 0) begin
            hold_left--;
            rx_stall_next = 1'b1;
         end else begin
            case (rx_mode)
               0:       rx_stall_next = 1'b0;
               1:       rx_stall_next = ($urandom_range(0, 3) == 0);
               2:       rx_stall_next = ($urandom_range(0, 3) != 0);
               default: rx_stall_next = ((rx_cycle % 5) < 2);
            endcase
         end
         rsp_stall <= rx_stall_next;
      end
   end

   // ------------------------------------------------------------------
   // Watchdog: too long without any transaction ends the run
   // ------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired: %0d responses outstanding", pending_rsps.size());
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------
   // Sequencer helpers
   // ------------------------------------------------------------------
   task automatic push_req(input logic op, input logic [ADDR_W-1:0] addr);
      fbpa_pkg::req_type r;
      r.operation = op;
      r.address   = addr;
      pending_reqs.push_back(r);
      n_queued++;
   endtask

   // wait until every queued transaction has its response, then let the block settle
   task automatic wait_drained();
      while (n_rsps < n_queued)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // APB write (setup, access) then read-back; the shadow follows the write edge
   task automatic csr_set(input logic [1:0] idx, input logic [PDATA_W-1:0] value);
      logic [PDATA_W-1:0] readback;
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         fbpa_pkg::REG_BASE_ADDRESS: cfg_base = value;
         fbpa_pkg::REG_BLOCK_SIZE:   cfg_size = value[CFG_SIZE_W-1:0];
         default: begin
            cfg_count = value[CFG_COUNT_W-1:0];
            refill_pool();
         end
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      case (idx)
         fbpa_pkg::REG_BASE_ADDRESS: readback = cfg_base;
         fbpa_pkg::REG_BLOCK_SIZE:   readback = PDATA_W'(cfg_size);
         default:                    readback = PDATA_W'(cfg_count);
      endcase
      if (prdata !== readback) begin
         $error("prdata reg %0d: expected %h, got %h", idx, readback, prdata);
         errors++;
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // random traffic for the current setting: mostly allocates and frees of
   // real block addresses, the rest null, misaligned, past-end and noise
   task automatic queue_random(input int n_items, input int alloc_pct);
      int unsigned blocks;
      int unsigned k;
      int unsigned sel;
      logic [ADDR_W-1:0] addr;
      blocks = pool_blocks();
      repeat (n_items) begin
         sel  = $urandom_range(0, 99);
         k    = (blocks == 0) ? 0 : $urandom_range(0, blocks - 1);
         addr = $urandom;
         if (sel < alloc_pct)
            push_req(fbpa_pkg::OP_ALLOC, addr);
         else if (sel < 88)
            push_req(fbpa_pkg::OP_FREE, cfg_base + k * cfg_size);
         else if (sel < 91)
            push_req(fbpa_pkg::OP_FREE, '0);
         else if (sel < 95)
            push_req(fbpa_pkg::OP_FREE, cfg_base + k * cfg_size +
                     ((cfg_size > 1) ? $urandom_range(1, cfg_size - 1) : 1));
         else if (sel < 98)
            push_req(fbpa_pkg::OP_FREE, cfg_base + (blocks + k) * cfg_size);
         else
            push_req(fbpa_pkg::OP_FREE, addr);
      end
   endtask

   // ------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------
   initial begin
      logic [ADDR_W-1:0]      pick_base;
      logic [CFG_SIZE_W-1:0]  pick_size;
      logic [CFG_COUNT_W-1:0] pick_count;

      cfg_base  = fbpa_pkg::BASE_RESET;
      cfg_size  = fbpa_pkg::SIZE_RESET;
      cfg_count = fbpa_pkg::COUNT_RESET;
      refill_pool();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      n_settings = 1;

      // reset defaults: base 0, 64-byte blocks, full list of 1024
      push_req(fbpa_pkg::OP_FREE, '0);                 // null
      push_req(fbpa_pkg::OP_FREE, 32'd64);             // valid, list full
      push_req(fbpa_pkg::OP_FREE, 32'd65);             // misaligned
      push_req(fbpa_pkg::OP_FREE, 32'd65536);          // one past the pool
      push_req(fbpa_pkg::OP_FREE, 32'hFFFF_FFFF);
      push_req(fbpa_pkg::OP_ALLOC, 32'hFFFF_FFFF);     // address ignored, top index 1023
      push_req(fbpa_pkg::OP_ALLOC, '0);
      push_req(fbpa_pkg::OP_FREE, 32'd65472);
      push_req(fbpa_pkg::OP_FREE, 32'd65472);          // double free still fits
      push_req(fbpa_pkg::OP_FREE, 32'd65472);          // now full
      wait_drained();

      // pool wrapping past 2^32 with the largest block size
      csr_set(fbpa_pkg::REG_BASE_ADDRESS, 32'hFFFF_FFF0);
      csr_set(fbpa_pkg::REG_BLOCK_SIZE, 32'h0000_FFFF);
      csr_set(fbpa_pkg::REG_BLOCK_COUNT, 32'd3);
      n_settings++;
      repeat (4) push_req(fbpa_pkg::OP_ALLOC, '0);     // three blocks then empty
      push_req(fbpa_pkg::OP_FREE, 32'h0000_FFEF);      // block 1, wrapped
      push_req(fbpa_pkg::OP_FREE, 32'hFFFF_FFF0);      // block 0
      push_req(fbpa_pkg::OP_FREE, 32'h0001_FFEE);      // block 2
      push_req(fbpa_pkg::OP_FREE, 32'hFFFF_FFF0);      // full
      wait_drained();

      // empty pool
      csr_set(fbpa_pkg::REG_BLOCK_COUNT, 32'd0);
      n_settings++;
      push_req(fbpa_pkg::OP_ALLOC, '0);
      push_req(fbpa_pkg::OP_FREE, 32'h10);
      wait_drained();

      // zero block size, count above the stack depth (capped)
      csr_set(fbpa_pkg::REG_BLOCK_SIZE, 32'd0);
      csr_set(fbpa_pkg::REG_BLOCK_COUNT, 32'd2047);
      n_settings++;
      push_req(fbpa_pkg::OP_ALLOC, '0);
      push_req(fbpa_pkg::OP_FREE, 32'hFFFF_FFF0);
      wait_drained();

      // single one-byte block at address 0
      csr_set(fbpa_pkg::REG_BASE_ADDRESS, 32'd0);
      csr_set(fbpa_pkg::REG_BLOCK_SIZE, 32'd1);
      csr_set(fbpa_pkg::REG_BLOCK_COUNT, 32'd1);
      n_settings++;
      push_req(fbpa_pkg::OP_ALLOC, '0);
      push_req(fbpa_pkg::OP_ALLOC, '0);
      push_req(fbpa_pkg::OP_FREE, '0);
      push_req(fbpa_pkg::OP_FREE, 32'd1);
      wait_drained();

      // random settings, each followed by a batch of random traffic
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case ($urandom_range(0, 3))
            0:       pick_base = '0;
            1:       pick_base = $urandom;
            2:       pick_base = 32'hFFFF_FFFF - $urandom_range(0, 8191);
            default: pick_base = 32'h8000_0000;
         endcase
         case ($urandom_range(0, 4))
            0:       pick_size = CFG_SIZE_W'($urandom_range(1, 16));
            1:       pick_size = 16'd1 << $urandom_range(0, 15);
            2:       pick_size = CFG_SIZE_W'($urandom_range(1, 65535));
            3:       pick_size = 16'hFFFF;
            default: pick_size = CFG_SIZE_W'($urandom_range(17, 300));
         endcase
         case ($urandom_range(0, 5))
            0, 1, 2: pick_count = CFG_COUNT_W'($urandom_range(1, 24));
            3:       pick_count = CFG_COUNT_W'($urandom_range(25, 1023));
            4:       pick_count = 11'd1024;
            default: pick_count = CFG_COUNT_W'($urandom_range(1025, 2047));
         endcase
         // base/size changes alone keep the stack; unused upper data bits are junk
         if (ph == 0 || $urandom_range(0, 3) != 0)
            csr_set(fbpa_pkg::REG_BASE_ADDRESS, pick_base);
         if (ph == 0 || $urandom_range(0, 3) != 0)
            csr_set(fbpa_pkg::REG_BLOCK_SIZE, {16'($urandom), pick_size});
         if (ph == 0 || $urandom_range(0, 3) != 0)
            csr_set(fbpa_pkg::REG_BLOCK_COUNT, {21'($urandom), pick_count});
         n_settings++;

         // long receiver hold-off while the sender keeps offering
         if (ph == 3)
            hold_request <= hold_request + 1;

         if (ph == 6) begin
            // sender pauses mid-batch until every response is back
            queue_random(PHASE_ITEMS / 2, $urandom_range(30, 60));
            wait_drained();
            queue_random(PHASE_ITEMS - PHASE_ITEMS / 2, $urandom_range(30, 60));
         end else begin
            queue_random(PHASE_ITEMS, $urandom_range(30, 60));
         end
         wait_drained();
      end

      // tail: catch any stray response
      repeat (40) @(posedge clock);

      $display("covered %0d transactions under %0d register settings, %0d responses seen",
               n_queued, n_settings, n_rsps);
      $display("status mix: ok %0d, empty %0d, null %0d, invalid %0d, full %0d",
               status_seen[fbpa_pkg::STATUS_OK],
               status_seen[fbpa_pkg::STATUS_EMPTY],
               status_seen[fbpa_pkg::STATUS_NULL],
               status_seen[fbpa_pkg::STATUS_INVALID],
               status_seen[fbpa_pkg::STATUS_FULL]);
      if (errors == 0 && pending_rsps.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
